@@ hw/rtl/mono_to_4bpp_color_expand_macros.svh @@
// Assertion macros shared by the color expander checker
`ifndef MONO_TO_4BPP_COLOR_EXPAND_MACROS_SVH
`define MONO_TO_4BPP_COLOR_EXPAND_MACROS_SVH

// same-cycle implication
`define M4C_ASSERT_IMP(name, clk, rst, a, c) \
   name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("color expand check failed");

// next-cycle implication
`define M4C_ASSERT_NXT(name, clk, rst, a, c) \
   name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("color expand check failed");

`endif

@@ hw/rtl/m4c_pkg.sv @@
// Types and constants of the mono to 4bpp color expander
package m4c_pkg;

   localparam int REG_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int LANES       = 8;
   localparam int SLOTS       = 10;
   localparam int ROW_CNT_W   = 12;
   localparam int BYTE_IDX_W  = 10;
   localparam int COL_W       = 13;
   localparam int PROD_W      = 24;
   localparam int OUT_ADDR_W  = 24;
   localparam int SPAN_W      = 40;
   localparam int RSP_DATA_W  = 80;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_DEST_X         = 3'd0,
      REG_DEST_Y         = 3'd1,
      REG_LINE_BYTES     = 3'd2,
      REG_SRC_BIT_OFFSET = 3'd3,
      REG_BLIT_WIDTH     = 3'd4,
      REG_BLIT_HEIGHT    = 3'd5,
      REG_COLORS         = 3'd6,
      REG_USE_BG         = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [11:0] dest_x;
      logic [11:0] dest_y;
      logic [11:0] line_bytes;
      logic [2:0]  src_bit_offset;
      logic [12:0] blit_width;
      logic [12:0] blit_height;
      logic [7:0]  colors;
      logic        use_bg;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      dest_x:         12'd0,
      dest_y:         12'd0,
      line_bytes:     12'd320,
      src_bit_offset: 3'd0,
      blit_width:     13'd1,
      blit_height:    13'd1,
      colors:         8'hf0,
      use_bg:         1'b1
   };

   typedef struct packed {
      logic [7:0]        bits;
      logic [2:0]        first_bit;
      logic [2:0]        last_bit;
      logic              x0_odd;
      logic [11:0]       col_byte;
      logic              load_base;
      logic [PROD_W-1:0] prod;
      logic [11:0]       line_bytes;
      logic              is_last;
      logic              blit_done;
   } desc_type;

endpackage

@@ hw/rtl/m4c_lane.sv @@
// One pixel lane: color and enable of a single source bit
module m4c_lane (
   input  logic       pix,
   input  logic       active,
   input  logic       use_bg,
   input  logic [3:0] fg,
   input  logic [3:0] bg,
   output logic [3:0] nib,
   output logic       en
);

   assign en  = active && (pix || use_bg);
   assign nib = en ? (pix ? fg : bg) : 4'h0;

endmodule

@@ hw/rtl/m4c_merge.sv @@
// Merge stage: align lane nibbles into the five-byte span
module m4c_merge (
   input  logic [m4c_pkg::LANES-1:0][3:0] lane_nib,
   input  logic [m4c_pkg::LANES-1:0]      lane_en,
   input  logic [2:0]                     first_bit,
   input  logic                           x0_odd,
   output logic [m4c_pkg::SPAN_W-1:0]     span_data,
   output logic [m4c_pkg::SLOTS-1:0]      nibble_enable
);

   always_comb begin
      int idx;
      int pos;
      span_data     = '0;
      nibble_enable = '0;
      for (int j = 0; j < m4c_pkg::SLOTS; j++) begin
         idx = j + int'(first_bit) - int'(x0_odd);
         pos = j ^ 1;
         if (idx >= 0 && idx < m4c_pkg::LANES) begin
            if (lane_en[3'(idx)]) begin
               span_data[4*pos +: 4] = lane_nib[3'(idx)];
               nibble_enable[pos]    = 1'b1;
            end
         end
      end
   end

endmodule

@@ hw/rtl/m4c_ctrl.sv @@
// Row and byte sequencer: tracks position and builds the item descriptor
module m4c_ctrl #(
   parameter int COORD_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         src_byte,
   input  m4c_pkg::cfg_type   cfg,
   output m4c_pkg::desc_type  desc
);

   localparam int CW = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
   localparam logic [CW-1:0] COORD_MAX = CW'(1) << COORD_BITS;
   localparam logic [31:0] COORD_MASK = (32'd1 << COORD_BITS) - 32'd1;

   logic [m4c_pkg::BYTE_IDX_W-1:0] bir_ff, bir_in;
   logic [m4c_pkg::ROW_CNT_W-1:0]  rc_ff, rc_in;
   logic [m4c_pkg::COL_W-1:0]      nc_ff, nc_in;

   logic [CW-1:0]  bw, bh, w, h;
   logic [CW:0]    span_end;
   logic [CW:0]    last_idx;
   logic           row_first;
   logic           is_last;
   logic           done;
   logic [2:0]     first_bit, last_bit;
   logic [3:0]     n;
   logic [11:0]    dx_m, dy_m;
   logic [m4c_pkg::COL_W-1:0] x0;

   always_comb begin
      bw = CW'(cfg.blit_width);
      bh = CW'(cfg.blit_height);
      if (bw == '0) begin
         w = CW'(1);
      end else if (bw > COORD_MAX) begin
         w = COORD_MAX;
      end else begin
         w = bw;
      end
      if (bh == '0) begin
         h = CW'(1);
      end else if (bh > COORD_MAX) begin
         h = COORD_MAX;
      end else begin
         h = bh;
      end
      span_end  = (CW+1)'(cfg.src_bit_offset) + (CW+1)'(w) - (CW+1)'(1);
      last_idx  = span_end >> 3;
      row_first = (bir_ff == '0);
      is_last   = ((CW+1)'(bir_ff) >= last_idx);
      first_bit = row_first ? cfg.src_bit_offset : 3'd0;
      last_bit  = is_last ? span_end[2:0] : 3'd7;
      n         = (last_bit >= first_bit) ?
                  ({1'b0, last_bit} - {1'b0, first_bit} + 4'd1) : 4'd0;
      dx_m      = cfg.dest_x & 12'(COORD_MASK);
      dy_m      = cfg.dest_y & 12'(COORD_MASK);
      x0        = row_first ? {1'b0, dx_m} : nc_ff;
      done      = (CW'(rc_ff) + CW'(1) >= h);
   end

   always_comb begin
      desc.bits       = src_byte;
      desc.first_bit  = first_bit;
      desc.last_bit   = last_bit;
      desc.x0_odd     = x0[0];
      desc.col_byte   = x0[m4c_pkg::COL_W-1:1];
      desc.load_base  = row_first && (rc_ff == '0);
      desc.prod       = m4c_pkg::PROD_W'(dy_m) * m4c_pkg::PROD_W'(cfg.line_bytes);
      desc.line_bytes = cfg.line_bytes;
      desc.is_last    = is_last;
      desc.blit_done  = is_last && done;
   end

   always_comb begin
      bir_in = bir_ff;
      rc_in  = rc_ff;
      nc_in  = nc_ff;
      if (accept) begin
         nc_in = x0 + m4c_pkg::COL_W'(n);
         if (is_last) begin
            bir_in = '0;
            rc_in  = done ? '0 : rc_ff + 1'b1;
         end else begin
            bir_in = bir_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bir_ff <= '0;
         rc_ff  <= '0;
         nc_ff  <= '0;
      end else begin
         bir_ff <= bir_in;
         rc_ff  <= rc_in;
         nc_ff  <= nc_in;
      end
   end

endmodule

@@ hw/rtl/mono_to_4bpp_color_expand.sv @@
// Top level of the mono to 4bpp color expander
//
//   channel   dir   contents
//   req_*     in    tdata[7:0] src_byte
//   rsp_*     out   tdata: byte_address, span_data, nibble_enable; tlast row_end;
//                   tuser blit_end
//   csr_*     in    index 0..7 selects the register, data in csr_wdata
//
// One byte per cycle sustained while rsp_tready stays high; each result passes
// the two-stage path: descriptor register, then lanes, merge and address add
// into the output register.
// Reset loads the register defaults and clears row, byte and column tracking.
// rsp_tready low holds the output; req_tready drops while both stages are full
// and rsp_tready is low.
module mono_to_4bpp_color_expand #(
   parameter int ADDR_BITS  = 24,
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] src_byte
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [23:0] byte_address, [63:24] span_data, [73:64] nibble_enable, rest zero
   output logic [m4c_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser,   // [0] blit_end
   input  logic                                  csr_we,
   input  logic [m4c_pkg::REG_IDX_W-1:0]         csr_index,
   input  logic [m4c_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   m4c_pkg::cfg_type  cfg_ff, cfg_in;
   m4c_pkg::desc_type desc, s1_ff, s1_in;
   logic              s1_valid_ff, s1_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              adv_b, adv_a, accept, move;

   logic [ADDR_BITS-1:0] row_off_ff, row_off_in;
   logic [ADDR_BITS-1:0] base, addr;

   logic [m4c_pkg::OUT_ADDR_W-1:0] addr_ff, addr_in;
   logic [m4c_pkg::SPAN_W-1:0]     span_ff, span_in;
   logic [m4c_pkg::SLOTS-1:0]      en_ff, en_in;
   logic                           row_end_ff, row_end_in;
   logic                           blit_end_ff, blit_end_in;

   logic [m4c_pkg::LANES-1:0][3:0] lane_nib;
   logic [m4c_pkg::LANES-1:0]      lane_en;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (m4c_pkg::reg_index_type'(csr_index))
            m4c_pkg::REG_DEST_X:         cfg_in.dest_x         = csr_wdata[11:0];
            m4c_pkg::REG_DEST_Y:         cfg_in.dest_y         = csr_wdata[11:0];
            m4c_pkg::REG_LINE_BYTES:     cfg_in.line_bytes     = csr_wdata[11:0];
            m4c_pkg::REG_SRC_BIT_OFFSET: cfg_in.src_bit_offset = csr_wdata[2:0];
            m4c_pkg::REG_BLIT_WIDTH:     cfg_in.blit_width     = csr_wdata;
            m4c_pkg::REG_BLIT_HEIGHT:    cfg_in.blit_height    = csr_wdata;
            m4c_pkg::REG_COLORS:         cfg_in.colors         = csr_wdata[7:0];
            m4c_pkg::REG_USE_BG:         cfg_in.use_bg         = csr_wdata[0];
            default:                     cfg_in                = cfg_ff;
         endcase
      end
   end

   assign adv_b      = !rsp_valid_ff || rsp_tready;
   assign adv_a      = !s1_valid_ff || adv_b;
   assign req_tready = adv_a;
   assign accept     = req_tvalid && adv_a;
   assign move       = s1_valid_ff && adv_b;

   m4c_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .src_byte (req_tdata),
      .cfg      (cfg_ff),
      .desc     (desc)
   );

   assign s1_valid_in = adv_a ? req_tvalid : s1_valid_ff;
   assign s1_in       = accept ? desc : s1_ff;

   for (genvar i = 0; i < m4c_pkg::LANES; i++) begin : g_lane
      m4c_lane u_lane (
         .pix    (s1_ff.bits[m4c_pkg::LANES-1-i]),
         .active ((3'(i) >= s1_ff.first_bit) && (3'(i) <= s1_ff.last_bit)),
         .use_bg (cfg_ff.use_bg),
         .fg     (cfg_ff.colors[7:4]),
         .bg     (cfg_ff.colors[3:0]),
         .nib    (lane_nib[i]),
         .en     (lane_en[i])
      );
   end

   m4c_merge u_merge (
      .lane_nib      (lane_nib),
      .lane_en       (lane_en),
      .first_bit     (s1_ff.first_bit),
      .x0_odd        (s1_ff.x0_odd),
      .span_data     (span_in),
      .nibble_enable (en_in)
   );

   always_comb begin
      base        = s1_ff.load_base ? ADDR_BITS'(s1_ff.prod) : row_off_ff;
      addr        = base + ADDR_BITS'(s1_ff.col_byte);
      addr_in     = m4c_pkg::OUT_ADDR_W'(addr);
      row_end_in  = s1_ff.is_last;
      blit_end_in = s1_ff.blit_done;
      row_off_in  = row_off_ff;
      if (move) begin
         row_off_in = s1_ff.is_last ? base + ADDR_BITS'(s1_ff.line_bytes) : base;
      end
      rsp_valid_in = adv_b ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= m4c_pkg::CFG_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_off_ff   <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_off_ff   <= row_off_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      if (move) begin
         addr_ff     <= addr_in;
         span_ff     <= span_in;
         en_ff       <= en_in;
         row_end_ff  <= row_end_in;
         blit_end_ff <= blit_end_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, en_ff, span_ff, addr_ff};
   assign rsp_tlast  = row_end_ff;
   assign rsp_tuser  = blit_end_ff;

endmodule

@@ hw/rtl/m4c_checker.sv @@
// Port checker for the color expander, bound to the top level
`include "mono_to_4bpp_color_expand_macros.svh"

module m4c_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [m4c_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           rsp_tuser
);

   logic [m4c_pkg::SPAN_W-1:0] en_mask;
   logic                       stalled;

   always_comb begin
      for (int k = 0; k < m4c_pkg::SLOTS; k++) begin
         en_mask[4*k +: 4] = {4{rsp_tdata[64+k]}};
      end
   end

   assign stalled = rsp_tvalid && !rsp_tready;

   `M4C_ASSERT_NXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid)
   `M4C_ASSERT_IMP(a_blit_end_row_end, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `M4C_ASSERT_IMP(a_masked_nibbles, clock, reset, rsp_tvalid, (rsp_tdata[63:24] & ~en_mask) == '0)
   `M4C_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind mono_to_4bpp_color_expand m4c_checker u_m4c_checker (.*);

@@ tb/mono_to_4bpp_color_expand_tb.sv @@
// Self-checking testbench for the mono to 4bpp color expander: predicts every span write
module mono_to_4bpp_color_expand_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [23:0] byte_address;
      logic [39:0] span_data;
      logic [9:0]  nibble_enable;
      logic        row_end;
      logic        blit_end;
   } span_write_type;

   class span_scoreboard;
      m4c_pkg::cfg_type regs;
      logic [11:0]      row_count;
      logic [9:0]       byte_in_row;
      logic [12:0]      next_column;
      logic [23:0]      row_start_offset;
      span_write_type   pending_spans[$];
      int               errors;

      function new();
         regs = m4c_pkg::CFG_RESET;
         row_count = '0;
         byte_in_row = '0;
         next_column = '0;
         row_start_offset = '0;
         errors = 0;
      endfunction

      function void write_reg(m4c_pkg::reg_index_type idx, logic [12:0] value);
         case (idx)
            m4c_pkg::REG_DEST_X:         regs.dest_x = value[11:0];
            m4c_pkg::REG_DEST_Y:         regs.dest_y = value[11:0];
            m4c_pkg::REG_LINE_BYTES:     regs.line_bytes = value[11:0];
            m4c_pkg::REG_SRC_BIT_OFFSET: regs.src_bit_offset = value[2:0];
            m4c_pkg::REG_BLIT_WIDTH:     regs.blit_width = value;
            m4c_pkg::REG_BLIT_HEIGHT:    regs.blit_height = value;
            m4c_pkg::REG_COLORS:         regs.colors = value[7:0];
            m4c_pkg::REG_USE_BG:         regs.use_bg = value[0];
            default: ;
         endcase
      endfunction

      function int clamp_dim(logic [12:0] v);
         if (v == 0) return 1;
         if (v > 4096) return 4096;
         return int'(v);
      endfunction

      function int bytes_per_blit();
         return (((int'(regs.src_bit_offset) + clamp_dim(regs.blit_width) - 1) >> 3) + 1)
                * clamp_dim(regs.blit_height);
      endfunction

      function void note_byte(logic [7:0] pixels);
         int             width;
         int             height;
         int             sbo;
         int             last_idx;
         int             first_bit;
         int             last_bit;
         int             n;
         int             slot;
         int             pos;
         logic           lit;
         span_write_type s;
         width = clamp_dim(regs.blit_width);
         height = clamp_dim(regs.blit_height);
         sbo = int'(regs.src_bit_offset);
         last_idx = (sbo + width - 1) >> 3;
         if (byte_in_row == 0) begin
            next_column = {1'b0, regs.dest_x};
            if (row_count == 0)
               row_start_offset = {12'd0, regs.dest_y} * {12'd0, regs.line_bytes};
         end
         s.row_end = (int'(byte_in_row) >= last_idx);
         first_bit = (byte_in_row == 0) ? sbo : 0;
         last_bit = s.row_end ? ((sbo + width - 1) & 7) : 7;
         n = (last_bit >= first_bit) ? last_bit - first_bit + 1 : 0;
         s.span_data = '0;
         s.nibble_enable = '0;
         for (int i = 0; i < n; i++) begin
            lit = pixels[7 - first_bit - i];
            slot = int'(next_column[0]) + i;
            pos = (slot >> 1) * 2 + (((slot & 1) == 0) ? 1 : 0);
            if (lit || regs.use_bg) begin
               s.span_data[4*pos +: 4] = lit ? regs.colors[7:4] : regs.colors[3:0];
               s.nibble_enable[pos] = 1'b1;
            end
         end
         s.byte_address = row_start_offset + (next_column >> 1);
         s.blit_end = 1'b0;
         next_column = next_column + 13'(n);
         if (s.row_end) begin
            byte_in_row = '0;
            row_start_offset = row_start_offset + {12'd0, regs.line_bytes};
            if (int'(row_count) + 1 >= height) begin
               row_count = '0;
               s.blit_end = 1'b1;
            end else begin
               row_count = row_count + 12'd1;
            end
         end else begin
            byte_in_row = byte_in_row + 10'd1;
         end
         pending_spans.push_back(s);
      endfunction

      task report(string msg);
         errors++;
         $display("%0t: %s", $time, msg);
      endtask

      task compare(string field, logic [39:0] seen, logic [39:0] want);
         if (seen !== want)
            report($sformatf("%s is %0h, want %0h", field, seen, want));
      endtask

      task check_span(span_write_type seen);
         span_write_type want;
         if (pending_spans.size() == 0) begin
            report("span write with nothing outstanding");
            return;
         end
         want = pending_spans.pop_front();
         compare("byte_address", 40'(seen.byte_address), 40'(want.byte_address));
         compare("span_data", seen.span_data, want.span_data);
         compare("nibble_enable", 40'(seen.nibble_enable), 40'(want.nibble_enable));
         compare("row_end", 40'(seen.row_end), 40'(want.row_end));
         compare("blit_end", 40'(seen.blit_end), 40'(want.blit_end));
      endtask

      function int outstanding();
         return pending_spans.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = 8'd0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [m4c_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   logic                           rsp_tuser;
   logic                           csr_we = 1'b0;
   m4c_pkg::reg_index_type         csr_index = m4c_pkg::REG_DEST_X;
   logic [m4c_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int             req_gap_pct = 19;
   int             rsp_stall_pct = 82;
   int             cycle_count = 0;
   span_scoreboard sb = new();

   mono_to_4bpp_color_expand DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      span_write_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            seen.byte_address = rsp_tdata[23:0];
            seen.span_data = rsp_tdata[63:24];
            seen.nibble_enable = rsp_tdata[73:64];
            seen.row_end = rsp_tlast;
            seen.blit_end = rsp_tuser;
            sb.check_span(seen);
         end
      end
   end

   task send_byte(logic [7:0] value);
      while ($urandom_range(99) < req_gap_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata <= 8'($urandom);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   task send_blit(int count);
      repeat (count) send_byte(8'($urandom));
   endtask

   // drop valid and hold until every span write is back
   task drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task write_reg(m4c_pkg::reg_index_type idx, logic [12:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function logic [11:0] pick_coord();
      case ($urandom_range(9))
         0: return 12'd0;
         1: return 12'hfff;
         default: return 12'($urandom);
      endcase
   endfunction

   function logic [12:0] pick_dim(int typical);
      case ($urandom_range(19))
         0: return 13'd0;
         1: return 13'($urandom_range(4097, 8191));
         2: return 13'd4096;
         default: return 13'($urandom_range(1, typical));
      endcase
   endfunction

   task new_random_setting();
      if ($urandom_range(1)) write_reg(m4c_pkg::REG_DEST_X, {1'b0, pick_coord()});
      if ($urandom_range(1)) write_reg(m4c_pkg::REG_DEST_Y, {1'b0, pick_coord()});
      if ($urandom_range(1)) write_reg(m4c_pkg::REG_LINE_BYTES, {1'b0, pick_coord()});
      if ($urandom_range(1))
         write_reg(m4c_pkg::REG_SRC_BIT_OFFSET, 13'($urandom_range(7)));
      if ($urandom_range(1)) write_reg(m4c_pkg::REG_BLIT_WIDTH, pick_dim(40));
      if ($urandom_range(1)) write_reg(m4c_pkg::REG_BLIT_HEIGHT, pick_dim(4));
      if ($urandom_range(1)) write_reg(m4c_pkg::REG_COLORS, 13'($urandom_range(255)));
      if ($urandom_range(1)) write_reg(m4c_pkg::REG_USE_BG, 13'($urandom_range(1)));
      end_writes();
   endtask

   initial begin
      int sent;
      int blit_len;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default registers: one pixel, set then clear
      send_byte(8'h80);
      send_byte(8'h00);
      drain();

      // far corner with address wrap, odd column, transparent clear bits
      write_reg(m4c_pkg::REG_DEST_X, 13'd4095);
      write_reg(m4c_pkg::REG_DEST_Y, 13'd4095);
      write_reg(m4c_pkg::REG_LINE_BYTES, 13'd4095);
      write_reg(m4c_pkg::REG_SRC_BIT_OFFSET, 13'd7);
      write_reg(m4c_pkg::REG_BLIT_WIDTH, 13'd9);
      write_reg(m4c_pkg::REG_BLIT_HEIGHT, 13'd4);
      write_reg(m4c_pkg::REG_COLORS, 13'h5a);
      write_reg(m4c_pkg::REG_USE_BG, 13'd0);
      end_writes();
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'hfe);
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(8'h7f);
      send_byte(8'haa);
      send_byte(8'h55);
      drain();

      // zero width and height count as one
      write_reg(m4c_pkg::REG_BLIT_WIDTH, 13'd0);
      write_reg(m4c_pkg::REG_BLIT_HEIGHT, 13'd0);
      write_reg(m4c_pkg::REG_DEST_X, 13'd0);
      write_reg(m4c_pkg::REG_DEST_Y, 13'd0);
      write_reg(m4c_pkg::REG_LINE_BYTES, 13'd0);
      write_reg(m4c_pkg::REG_SRC_BIT_OFFSET, 13'd0);
      write_reg(m4c_pkg::REG_COLORS, 13'h0f);
      write_reg(m4c_pkg::REG_USE_BG, 13'd1);
      end_writes();
      send_byte(8'h7f);
      send_byte(8'h80);
      drain();

      // shrink the width mid-row so the next byte lands past the row end
      write_reg(m4c_pkg::REG_BLIT_WIDTH, 13'd8191);
      write_reg(m4c_pkg::REG_BLIT_HEIGHT, 13'd1);
      write_reg(m4c_pkg::REG_DEST_X, 13'd4094);
      write_reg(m4c_pkg::REG_COLORS, 13'hc3);
      write_reg(m4c_pkg::REG_USE_BG, 13'd0);
      end_writes();
      send_blit(3);
      drain();
      write_reg(m4c_pkg::REG_BLIT_WIDTH, 13'd8);
      end_writes();
      send_blit(2);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_gap_pct = 19; rsp_stall_pct = 82; end
            1: begin req_gap_pct = 82; rsp_stall_pct = 19; end
            default: begin req_gap_pct = 0; rsp_stall_pct = 0; end
         endcase
         sent = 0;
         while (sent < 160) begin
            new_random_setting();
            blit_len = sb.bytes_per_blit();
            if (blit_len > 120 || $urandom_range(7) == 0)
               blit_len = $urandom_range(1, 24);
            send_blit(blit_len);
            sent += blit_len;
            drain();
         end
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("mono_to_4bpp_color_expand regression: pass");
      else
         $display("mono_to_4bpp_color_expand regression: fail");
      $finish;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("mono_to_4bpp_color_expand regression: fail");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/m4c_pkg.sv
hw/rtl/m4c_lane.sv
hw/rtl/m4c_merge.sv
hw/rtl/m4c_ctrl.sv
hw/rtl/mono_to_4bpp_color_expand.sv
hw/rtl/m4c_checker.sv
tb/mono_to_4bpp_color_expand_tb.sv
